@@ rtl/core/spr_pkg.sv @@
// Shared constants and types of the sphere point rotate and project core.
package spr_pkg;

  localparam int ANGLE_STEPS = 1024;
  localparam int SCREEN_SIZE = 240;
  localparam int ONE_Q14     = 16384;

  localparam int STEP_W  = 11;
  localparam int CFG_W   = 10;
  localparam int PIX_W   = 8;
  localparam int REG_N   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROLL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW   = 2'd2;

  typedef logic signed [STEP_W-1:0] step_t;
  typedef logic [CFG_W-1:0]         cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [PIX_W-1:0]         pix_t;

endpackage

@@ rtl/core/spr_if.sv @@
// Channel interfaces of the sphere point rotate and project core.
interface spr_pt_if import spr_pkg::*; ();
  logic  valid;
  logic  ready;
  step_t lat_steps;
  step_t lon_steps;

  modport source (output valid, output lat_steps, output lon_steps, input ready);
  modport sink (input valid, input lat_steps, input lon_steps, output ready);
endinterface

interface spr_res_if import spr_pkg::*; ();
  logic valid;
  logic ready;
  pix_t screen_x;
  pix_t screen_y;
  logic facing_viewer;

  modport source (output valid, output screen_x, output screen_y, output facing_viewer,
                  input ready);
  modport sink (input valid, input screen_x, input screen_y, input facing_viewer,
                output ready);
endinterface

interface spr_cfg_if import spr_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/sphere_point_rotate_project_core.sv @@
// Top level: rotates unit-sphere points by yaw, pitch and roll and projects them to screen.
//
//   channel  dir  payload                              transfer when
//   pt_i     in   lat_steps, lon_steps                 pt_i.valid & pt_i.ready
//   res_o    out  screen_x, screen_y, facing_viewer    res_o.valid & res_o.ready
//   cfg_i    in   index, data                          cfg_i.valid (ready always high)
//
// Every point passes nine register stages before its result is offered at res_o.
// One point is taken per cycle unless a stall at res_o has backed up to the input;
// products sit in stages one, two, four and six, sums after them.
// Each stage holds its own valid bit and takes new data when it is empty or its successor moves,
// so bubbles close up while the output waits. Reset clears the valid bits and the angle registers.
module sphere_point_rotate_project_core
  import spr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  spr_pt_if.sink    pt_i,
  spr_res_if.source res_o,
  spr_cfg_if.sink   cfg_i
);

  localparam int PH_W    = $clog2(ANGLE_STEPS);
  localparam int HALF    = ANGLE_STEPS / 2;
  localparam int QUARTER = ANGLE_STEPS / 4;
  localparam int IDX_W   = $clog2(QUARTER + 1);
  localparam int SIN_W   = 15;
  localparam int VAL_W   = SIN_W + 1;
  localparam int ANG_W   = STEP_W + 2;
  localparam int COORD_W = 20;
  localparam int PROD_W  = COORD_W + VAL_W;
  localparam int SCR_W   = COORD_W + $clog2(SCREEN_SIZE + 1) + 2;
  localparam int NST     = 9;

  localparam longint unsigned ANG_DEN = 64'd100 * 64'(ANGLE_STEPS);
  localparam longint unsigned TAYLOR_DEN [10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                  64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  typedef logic [SIN_W-1:0]          sin_tab_t [QUARTER+1];
  typedef logic signed [VAL_W-1:0]   val_t;
  typedef logic signed [ANG_W-1:0]   ang_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SCR_W-1:0]   scr_t;

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t          t;
    longint unsigned   x;
    longint unsigned   term;
    longint unsigned   pos;
    longint unsigned   neg;
    longint unsigned   s;
    for (int i = 0; i <= QUARTER; i++) begin
      x    = ((longint'(i) * 64'd628) << 30) / ANG_DEN;
      term = x;
      pos  = x;
      neg  = 0;
      for (int k = 1; k <= 10; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TAYLOR_DEN[k-1];
        if (k % 2 == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      s    = (pos > neg) ? pos - neg : 64'd0;
      t[i] = SIN_W'((s + 64'd32768) >> 16);
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  function automatic val_t sin_steps(ang_t a);
    logic             neg;
    logic [ANG_W-1:0] mag;
    logic [PH_W-1:0]  m;
    logic [IDX_W-1:0] idx;
    val_t             v;
    neg = a[ANG_W-1];
    mag = neg ? ANG_W'(-a) : ANG_W'(a);
    m   = mag[PH_W-1:0];
    if (m >= PH_W'(HALF)) begin
      neg = !neg;
      m   = m - PH_W'(HALF);
    end
    if (m <= PH_W'(QUARTER)) begin
      idx = IDX_W'(m);
    end else begin
      idx = IDX_W'(PH_W'(HALF) - m);
    end
    v = val_t'({1'b0, SIN_TAB[idx]});
    return neg ? -v : v;
  endfunction

  function automatic coord_t qmul(coord_t a, val_t b);
    prod_t p;
    p = prod_t'(a) * prod_t'(b);
    return coord_t'(p >>> 14);
  endfunction

  function automatic pix_t to_screen(coord_t c);
    scr_t p;
    scr_t q;
    p = (scr_t'(c) + scr_t'(ONE_Q14)) * scr_t'(SCREEN_SIZE);
    q = p >>> 15;
    if (q < 0) begin
      q = '0;
    end else if (q > scr_t'(SCREEN_SIZE)) begin
      q = scr_t'(SCREEN_SIZE);
    end
    return PIX_W'(q);
  endfunction

  // Angle registers and their sine and cosine
  cfg_data_t roll_q, pitch_q, yaw_q;
  val_t      cy_q, sny_q, cp_q, sp_q, cr_q, sr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q  <= '0;
      pitch_q <= '0;
      yaw_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ROLL:  roll_q  <= cfg_i.data;
        REG_PITCH: pitch_q <= cfg_i.data;
        REG_YAW:   yaw_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cy_q  <= sin_steps(ang_t'(yaw_q) + ang_t'(QUARTER));
    sny_q <= sin_steps(-ang_t'(yaw_q));
    cp_q  <= sin_steps(ang_t'(pitch_q) + ang_t'(QUARTER));
    sp_q  <= sin_steps(ang_t'(pitch_q));
    cr_q  <= sin_steps(ang_t'(roll_q) + ang_t'(QUARTER));
    sr_q  <= sin_steps(ang_t'(roll_q));
  end

  // Pipeline control
  logic [NST-1:0] vld_q;
  logic [NST-1:0] adv;

  always_comb begin
    adv[NST-1] = !vld_q[NST-1] || res_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign pt_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= pt_i.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Pipeline data
  val_t   s0_clat_q, s0_slon_q, s0_slat_q, s0_clon_q;
  coord_t s1_x_q, s1_y_q, s1_z_q;
  coord_t s2_a_q, s2_b_q, s2_c_q, s2_d_q, s2_y_q;
  coord_t s3_x_q, s3_y_q, s3_z_q;
  coord_t s4_a_q, s4_b_q, s4_c_q, s4_d_q, s4_x_q;
  coord_t s5_x_q, s5_y_q;
  logic   s5_face_q;
  coord_t s6_a_q, s6_b_q, s6_c_q, s6_d_q;
  logic   s6_face_q;
  coord_t s7_x_q, s7_y_q;
  logic   s7_face_q;
  pix_t   s8_sx_q, s8_sy_q;
  logic   s8_face_q;
  coord_t s5_z_d;

  assign s5_z_d = s4_c_q + s4_d_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_clat_q <= sin_steps(ang_t'(pt_i.lat_steps) + ang_t'(QUARTER));
      s0_slon_q <= sin_steps(ang_t'(pt_i.lon_steps));
      s0_slat_q <= sin_steps(ang_t'(pt_i.lat_steps));
      s0_clon_q <= sin_steps(ang_t'(pt_i.lon_steps) + ang_t'(QUARTER));
    end
    if (adv[1]) begin
      s1_x_q <= qmul(coord_t'(s0_slon_q), s0_clat_q);
      s1_y_q <= coord_t'(s0_slat_q);
      s1_z_q <= qmul(coord_t'(s0_clon_q), s0_clat_q);
    end
    if (adv[2]) begin
      s2_a_q <= qmul(s1_x_q, cy_q);
      s2_b_q <= qmul(s1_z_q, sny_q);
      s2_c_q <= qmul(-s1_x_q, sny_q);
      s2_d_q <= qmul(s1_z_q, cy_q);
      s2_y_q <= s1_y_q;
    end
    if (adv[3]) begin
      s3_x_q <= s2_a_q + s2_b_q;
      s3_z_q <= s2_c_q + s2_d_q;
      s3_y_q <= s2_y_q;
    end
    if (adv[4]) begin
      s4_a_q <= qmul(s3_y_q, cp_q);
      s4_b_q <= qmul(s3_z_q, sp_q);
      s4_c_q <= qmul(-s3_y_q, sp_q);
      s4_d_q <= qmul(s3_z_q, cp_q);
      s4_x_q <= s3_x_q;
    end
    if (adv[5]) begin
      s5_x_q    <= s4_x_q;
      s5_y_q    <= s4_a_q + s4_b_q;
      s5_face_q <= !s5_z_d[COORD_W-1];
    end
    if (adv[6]) begin
      s6_a_q    <= qmul(s5_x_q, cr_q);
      s6_b_q    <= qmul(s5_y_q, sr_q);
      s6_c_q    <= qmul(-s5_x_q, sr_q);
      s6_d_q    <= qmul(s5_y_q, cr_q);
      s6_face_q <= s5_face_q;
    end
    if (adv[7]) begin
      s7_x_q    <= s6_a_q + s6_b_q;
      s7_y_q    <= s6_c_q + s6_d_q;
      s7_face_q <= s6_face_q;
    end
    if (adv[8]) begin
      s8_sx_q   <= to_screen(s7_x_q);
      s8_sy_q   <= to_screen(s7_y_q);
      s8_face_q <= s7_face_q;
    end
  end

  assign res_o.valid         = vld_q[NST-1];
  assign res_o.screen_x      = s8_sx_q;
  assign res_o.screen_y      = s8_sy_q;
  assign res_o.facing_viewer = s8_face_q;

endmodule

@@ rtl/core/spr_checker.sv @@
// Port-level checks of the sphere point rotate and project core, bound to the top level.
module spr_checker
  import spr_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input pix_t screen_x,
  input pix_t screen_y,
  input logic facing_viewer
);

  // A result that is not taken stays in place unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y)
                                && $stable(facing_viewer))
    else $error("stalled result changed");

  // The input is only held off while a finished result waits at the output.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> 32'(screen_x) <= 32'(SCREEN_SIZE))
    else $error("screen x beyond the screen");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> 32'(screen_y) <= 32'(SCREEN_SIZE))
    else $error("screen y beyond the screen");

endmodule

bind sphere_point_rotate_project_core spr_checker u_spr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready      (pt_i.ready),
  .out_valid     (res_o.valid),
  .out_ready     (res_o.ready),
  .screen_x      (res_o.screen_x),
  .screen_y      (res_o.screen_y),
  .facing_viewer (res_o.facing_viewer)
);
